@@ src/reversible_fifo_with_search_defines.svh @@
// ----------------------------------------------------------------------------
// Reversible FIFO with search - assertion macros
// Shared property forms for the checks at the top level.
// ----------------------------------------------------------------------------
`ifndef REVERSIBLE_FIFO_WITH_SEARCH_DEFINES_SVH
`define REVERSIBLE_FIFO_WITH_SEARCH_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define RFWS_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define RFWS_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ src/rfws_pkg.sv @@
// ----------------------------------------------------------------------------
// Reversible FIFO with search - package
// Sizes, operation and status codes, request, result and command types.
// ----------------------------------------------------------------------------
package rfws_pkg;

  localparam int QUEUE_DEPTH = 256;
  localparam int DATA_WIDTH  = 32;
  localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = ADDR_W + 1;

  localparam int CMDQ_DEPTH  = 2;
  localparam int CMDQ_PTR_W  = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W  = CMDQ_PTR_W + 1;

  localparam logic [2:0] OP_ENQUEUE  = 3'd0;
  localparam logic [2:0] OP_DEQUEUE  = 3'd1;
  localparam logic [2:0] OP_REVERSE  = 3'd2;
  localparam logic [2:0] OP_READ_NTH = 3'd3;
  localparam logic [2:0] OP_FIND     = 3'd4;

  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_FULL      = 3'd1;
  localparam logic [2:0] STAT_EMPTY     = 3'd2;
  localparam logic [2:0] STAT_RANGE     = 3'd3;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd4;

  typedef struct packed {
    logic [2:0]            operation;
    logic [DATA_WIDTH-1:0] data_value;
    logic [7:0]            entry_index;
  } request_t;

  typedef struct packed {
    logic [2:0]            status;
    logic [DATA_WIDTH-1:0] item_value;
    logic [7:0]            found_position;
    logic [DATA_WIDTH-1:0] front_value;
    logic [DATA_WIDTH-1:0] back_value;
    logic [8:0]            occupancy;
    logic                  is_empty;
  } result_t;

  typedef enum logic [2:0] {
    K_ENQUEUE,
    K_DEQUEUE,
    K_REVERSE,
    K_READ_NTH,
    K_FIND,
    K_IGNORE
  } kind_t;

  typedef struct packed {
    kind_t                 kind;
    logic [DATA_WIDTH-1:0] data_value;
    logic [7:0]            entry_index;
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ_WAIT,
    S_FRONT_WAIT,
    S_SCAN,
    S_DONE
  } back_state_t;

endpackage

@@ src/rfws_front.sv @@
// ----------------------------------------------------------------------------
// Reversible FIFO with search - front end
// Accepts requests, classifies the operation code and buffers the command
// in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module rfws_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              request_valid,
  output logic              request_ready,
  input  rfws_pkg::request_t request,
  output logic              cmd_valid,
  input  logic              cmd_pop,
  output rfws_pkg::cmd_t    cmd
);

  rfws_pkg::cmd_t                        slots [rfws_pkg::CMDQ_DEPTH];
  logic [rfws_pkg::CMDQ_PTR_W-1:0]       wr_ptr;
  logic [rfws_pkg::CMDQ_PTR_W-1:0]       rd_ptr;
  logic [rfws_pkg::CMDQ_CNT_W-1:0]       fill;
  rfws_pkg::cmd_t                        decoded;
  logic                                  push;
  logic                                  pop;

  always_comb begin
    decoded.data_value  = request.data_value;
    decoded.entry_index = request.entry_index;
    unique case (request.operation)
      rfws_pkg::OP_ENQUEUE:  decoded.kind = rfws_pkg::K_ENQUEUE;
      rfws_pkg::OP_DEQUEUE:  decoded.kind = rfws_pkg::K_DEQUEUE;
      rfws_pkg::OP_REVERSE:  decoded.kind = rfws_pkg::K_REVERSE;
      rfws_pkg::OP_READ_NTH: decoded.kind = rfws_pkg::K_READ_NTH;
      rfws_pkg::OP_FIND:     decoded.kind = rfws_pkg::K_FIND;
      default:               decoded.kind = rfws_pkg::K_IGNORE;
    endcase
  end

  assign request_ready = (fill != rfws_pkg::CMDQ_CNT_W'(rfws_pkg::CMDQ_DEPTH));
  assign cmd_valid     = (fill != '0);
  assign cmd           = slots[rd_ptr];
  assign push          = request_valid && request_ready;
  assign pop           = cmd_pop && cmd_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + rfws_pkg::CMDQ_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + rfws_pkg::CMDQ_PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   fill <= fill + rfws_pkg::CMDQ_CNT_W'(1);
        2'b01:   fill <= fill - rfws_pkg::CMDQ_CNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

@@ src/rfws_back.sv @@
// ----------------------------------------------------------------------------
// Reversible FIFO with search - back end
// Holds the ring buffer and its head, count and direction, carries out one
// command at a time and places the result in the output register.
// ----------------------------------------------------------------------------
module rfws_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_pop,
  input  rfws_pkg::cmd_t    cmd,
  output logic              result_valid,
  input  logic              result_ready,
  output rfws_pkg::result_t result
);

  localparam int AW = rfws_pkg::ADDR_W;
  localparam int CW = rfws_pkg::CNT_W;
  localparam int DW = rfws_pkg::DATA_WIDTH;

  logic [DW-1:0] mem [rfws_pkg::QUEUE_DEPTH];
  logic [DW-1:0] mem_rdata;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;

  rfws_pkg::back_state_t state, state_next;
  logic [AW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;
  logic          rev, rev_next;
  logic [DW-1:0] front_val, front_val_next;
  logic [DW-1:0] back_val, back_val_next;
  logic [AW-1:0] scan_i, scan_i_next;
  logic [DW-1:0] key, key_next;
  logic [2:0]    res_status, res_status_next;
  logic [DW-1:0] res_item, res_item_next;
  logic [7:0]    res_pos, res_pos_next;

  logic [AW-1:0] rd_logical;
  logic [AW-1:0] rd_off;
  logic [AW-1:0] rd_slot;
  logic          load_out;
  logic          is_empty_now;

  always_comb begin
    if (state == rfws_pkg::S_SCAN) begin
      rd_logical = scan_i + AW'(1);
    end else if (cmd.kind == rfws_pkg::K_READ_NTH) begin
      rd_logical = cmd.entry_index;
    end else begin
      rd_logical = '0;
    end
    rd_off  = rev ? (count[AW-1:0] - AW'(1) - rd_logical) : rd_logical;
    rd_slot = head + rd_off;
  end

  always_comb begin
    state_next      = state;
    head_next       = head;
    count_next      = count;
    rev_next        = rev;
    front_val_next  = front_val;
    back_val_next   = back_val;
    scan_i_next     = scan_i;
    key_next        = key;
    res_status_next = res_status;
    res_item_next   = res_item;
    res_pos_next    = res_pos;
    cmd_pop         = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = head + count[AW-1:0];
    mem_re          = 1'b0;
    mem_raddr       = rd_slot;
    load_out        = 1'b0;

    unique case (state)
      rfws_pkg::S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop         = 1'b1;
          key_next        = cmd.data_value;
          res_status_next = rfws_pkg::STAT_OK;
          res_item_next   = '0;
          res_pos_next    = '0;
          state_next      = rfws_pkg::S_DONE;
          unique case (cmd.kind)
            rfws_pkg::K_ENQUEUE: begin
              if (count[AW]) begin
                res_status_next = rfws_pkg::STAT_FULL;
              end else begin
                mem_we = 1'b1;
                if (rev) begin
                  head_next = head - AW'(1);
                  mem_waddr = head - AW'(1);
                end
                count_next    = count + CW'(1);
                back_val_next = cmd.data_value;
                if (count == '0) begin
                  front_val_next = cmd.data_value;
                end
              end
            end
            rfws_pkg::K_DEQUEUE: begin
              if (count == '0) begin
                res_status_next = rfws_pkg::STAT_EMPTY;
              end else begin
                if (!rev) begin
                  head_next = head + AW'(1);
                end
                count_next = count - CW'(1);
                if (count != CW'(1)) begin
                  mem_re     = 1'b1;
                  mem_raddr  = rev ? (head + count[AW-1:0] - AW'(2)) : (head + AW'(1));
                  state_next = rfws_pkg::S_FRONT_WAIT;
                end
              end
            end
            rfws_pkg::K_REVERSE: begin
              rev_next       = !rev;
              front_val_next = back_val;
              back_val_next  = front_val;
            end
            rfws_pkg::K_READ_NTH: begin
              if ({1'b0, cmd.entry_index} >= count) begin
                res_status_next = rfws_pkg::STAT_RANGE;
              end else begin
                mem_re     = 1'b1;
                state_next = rfws_pkg::S_READ_WAIT;
              end
            end
            rfws_pkg::K_FIND: begin
              if (count == '0) begin
                res_status_next = rfws_pkg::STAT_NOT_FOUND;
              end else begin
                mem_re      = 1'b1;
                scan_i_next = '0;
                state_next  = rfws_pkg::S_SCAN;
              end
            end
            default: begin
              res_status_next = rfws_pkg::STAT_OK;
            end
          endcase
        end
      end
      rfws_pkg::S_READ_WAIT: begin
        res_item_next = mem_rdata;
        state_next    = rfws_pkg::S_DONE;
      end
      rfws_pkg::S_FRONT_WAIT: begin
        front_val_next = mem_rdata;
        state_next     = rfws_pkg::S_DONE;
      end
      rfws_pkg::S_SCAN: begin
        if (mem_rdata == key) begin
          res_status_next = rfws_pkg::STAT_OK;
          res_pos_next    = 8'(scan_i);
          state_next      = rfws_pkg::S_DONE;
        end else if (({1'b0, scan_i} + CW'(1)) == count) begin
          res_status_next = rfws_pkg::STAT_NOT_FOUND;
          state_next      = rfws_pkg::S_DONE;
        end else begin
          mem_re      = 1'b1;
          scan_i_next = scan_i + AW'(1);
        end
      end
      rfws_pkg::S_DONE: begin
        if (!result_valid || result_ready) begin
          load_out   = 1'b1;
          state_next = rfws_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = rfws_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= key_next;
    end
    if (mem_re) begin
      mem_rdata <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rfws_pkg::S_IDLE;
      head  <= '0;
      count <= '0;
      rev   <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      rev   <= rev_next;
    end
  end

  always_ff @(posedge clk) begin
    front_val  <= front_val_next;
    back_val   <= back_val_next;
    scan_i     <= scan_i_next;
    key        <= key_next;
    res_status <= res_status_next;
    res_item   <= res_item_next;
    res_pos    <= res_pos_next;
  end

  assign is_empty_now = (count == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result.status         <= res_status;
      result.item_value     <= res_item;
      result.found_position <= res_pos;
      result.front_value    <= is_empty_now ? '0 : front_val;
      result.back_value     <= is_empty_now ? '0 : back_val;
      result.occupancy      <= 9'(count);
      result.is_empty       <= is_empty_now;
    end
  end

endmodule

@@ src/reversible_fifo_with_search.sv @@
// ----------------------------------------------------------------------------
// Reversible FIFO with search - top level
// Bounded ring-buffer queue of 256 words with enqueue, dequeue, reverse,
// indexed read and find; one result per request.
// ----------------------------------------------------------------------------
// Requests pass through a two-entry command queue and are then executed one
// at a time against an entry memory with one write port and one read port.
// Enqueue, reverse, ignored codes, a dequeue of the last entry and rejected
// requests go from idle straight to the done state, any other dequeue and an
// in-range read-nth pass through a wait state for one registered memory
// read, and find compares one entry per cycle through the memory read port.
// Reverse flips a direction bit and swaps the front and back values; no
// entry moves. The entry memory needs no clearing after reset.
`include "reversible_fifo_with_search_defines.svh"

module reversible_fifo_with_search (
  input  logic              clk,
  input  logic              rst,
  input  logic              request_valid,
  output logic              request_ready,
  input  rfws_pkg::request_t request,
  output logic              result_valid,
  input  logic              result_ready,
  output rfws_pkg::result_t result
);

  logic           cmd_valid;
  logic           cmd_pop;
  rfws_pkg::cmd_t cmd;

  rfws_front u_front (
    .clk          (clk),
    .rst          (rst),
    .request_valid(request_valid),
    .request_ready(request_ready),
    .request      (request),
    .cmd_valid    (cmd_valid),
    .cmd_pop      (cmd_pop),
    .cmd          (cmd)
  );

  rfws_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_pop     (cmd_pop),
    .cmd         (cmd),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

  `RFWS_ASSERT_NOW(a_pop_needs_cmd, cmd_pop, cmd_valid, "pop from empty command queue")
  `RFWS_ASSERT_NOW(a_empty_flag, result_valid, result.is_empty == (result.occupancy == 9'd0), "empty flag disagrees with occupancy")
  `RFWS_ASSERT_NOW(a_empty_zero, result_valid && result.is_empty, result.front_value == '0 && result.back_value == '0, "empty queue reports nonzero ends")
  `RFWS_ASSERT_NOW(a_full_drop, result_valid && result.status == rfws_pkg::STAT_FULL, result.occupancy == 9'd256, "drop reported below full")

endmodule

@@ tb/sv/reversible_fifo_with_search_tb.sv @@
// ----------------------------------------------------------------------------
// Reversible FIFO with search - testbench
// Drives enqueue, dequeue, reverse, read-nth and find requests, plus the
// unused operation codes, through the valid/ready request port. A mirror of
// the ring buffer (head, count, direction bit) predicts every result, and
// each returned result is compared field by field in order. Covers the
// empty and full edges, wrap of the head in both directions, whole-queue
// scans and random traffic with random stalls on both ports.
// ----------------------------------------------------------------------------
module reversible_fifo_with_search_tb;

  localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;
  localparam int unsigned CYCLE_LIMIT    = 4_000_000;
  localparam int unsigned DRAIN_CYCLES   = 20;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               request_valid = 1'b0;
  logic               request_ready;
  rfws_pkg::request_t request = '0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  rfws_pkg::result_t  result;

  logic [rfws_pkg::DATA_WIDTH-1:0] mirror_data [rfws_pkg::QUEUE_DEPTH];
  logic [rfws_pkg::ADDR_W-1:0]     mirror_head = '0;
  logic [rfws_pkg::CNT_W-1:0]      mirror_count = '0;
  logic                            mirror_reversed = 1'b0;

  rfws_pkg::result_t pending_results [$];
  int unsigned       mismatch_count = 0;
  int unsigned       cycle_count = 0;
  logic              idle_on = 1'b0;

  reversible_fifo_with_search DUT (
    .clk          (clk),
    .rst          (rst),
    .request_valid(request_valid),
    .request_ready(request_ready),
    .request      (request),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [rfws_pkg::ADDR_W-1:0] physical_slot(input int unsigned logical);
    int unsigned offset;
    offset = mirror_reversed ? (int'(mirror_count) - 1 - logical) : logical;
    return rfws_pkg::ADDR_W'(int'(mirror_head) + offset);
  endfunction

  function automatic logic [rfws_pkg::DATA_WIDTH-1:0] mirror_value(input int unsigned logical);
    return mirror_data[physical_slot(logical)];
  endfunction

  function automatic rfws_pkg::result_t predict_queue_result(input rfws_pkg::request_t req);
    rfws_pkg::result_t r;
    r = '0;
    r.status = rfws_pkg::STAT_OK;
    case (req.operation)
      rfws_pkg::OP_ENQUEUE: begin
        if (mirror_count == rfws_pkg::CNT_W'(rfws_pkg::QUEUE_DEPTH)) begin
          r.status = rfws_pkg::STAT_FULL;
        end else if (!mirror_reversed) begin
          mirror_data[mirror_head + mirror_count[rfws_pkg::ADDR_W-1:0]] = req.data_value;
          mirror_count = mirror_count + 1'b1;
        end else begin
          mirror_head = mirror_head - 1'b1;
          mirror_data[mirror_head] = req.data_value;
          mirror_count = mirror_count + 1'b1;
        end
      end
      rfws_pkg::OP_DEQUEUE: begin
        if (mirror_count == 0) begin
          r.status = rfws_pkg::STAT_EMPTY;
        end else begin
          if (!mirror_reversed) mirror_head = mirror_head + 1'b1;
          mirror_count = mirror_count - 1'b1;
        end
      end
      rfws_pkg::OP_REVERSE: begin
        mirror_reversed = !mirror_reversed;
      end
      rfws_pkg::OP_READ_NTH: begin
        if (rfws_pkg::CNT_W'(req.entry_index) >= mirror_count) r.status = rfws_pkg::STAT_RANGE;
        else r.item_value = mirror_value(req.entry_index);
      end
      rfws_pkg::OP_FIND: begin
        r.status = rfws_pkg::STAT_NOT_FOUND;
        for (int i = 0; i < int'(mirror_count); i++) begin
          if (mirror_value(i) == req.data_value) begin
            r.status = rfws_pkg::STAT_OK;
            r.found_position = 8'(i);
            break;
          end
        end
      end
      default: begin
      end
    endcase
    if (mirror_count != 0) begin
      r.front_value = mirror_value(0);
      r.back_value  = mirror_value(int'(mirror_count) - 1);
    end
    r.occupancy = mirror_count;
    r.is_empty  = (mirror_count == 0);
    return r;
  endfunction

  function automatic string fmt_result(input rfws_pkg::result_t r);
    return $sformatf("status=%0d item=%h pos=%0d front=%h back=%h occ=%0d empty=%b",
                     r.status, r.item_value, r.found_position, r.front_value,
                     r.back_value, r.occupancy, r.is_empty);
  endfunction

  task automatic send_request(input logic [2:0] op,
                              input logic [rfws_pkg::DATA_WIDTH-1:0] data,
                              input logic [7:0] idx);
    rfws_pkg::request_t req;
    req.operation   = op;
    req.data_value  = data;
    req.entry_index = idx;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      request_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    request_valid <= 1'b1;
    request       <= req;
    do @(posedge clk); while (!request_ready);
    pending_results.push_back(predict_queue_result(req));
  endtask

  // hold ready low in random bursts while idling is enabled
  initial begin
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 4) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) begin
          @(posedge clk);
          if (!idle_on) break;
        end
      end
      result_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    rfws_pkg::result_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_results.size() == 0) begin
        if (mismatch_count < 10) $display("unexpected result: %s", fmt_result(result));
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (result.status !== want.status || result.item_value !== want.item_value ||
            result.found_position !== want.found_position ||
            result.front_value !== want.front_value ||
            result.back_value !== want.back_value ||
            result.occupancy !== want.occupancy || result.is_empty !== want.is_empty) begin
          if (mismatch_count < 10) begin
            $display("mismatch: expected %s", fmt_result(want));
            $display("          actual   %s", fmt_result(result));
          end
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic test_directed_edges();
    send_request(rfws_pkg::OP_DEQUEUE, 32'h0, 8'h00);
    send_request(rfws_pkg::OP_READ_NTH, 32'h0, 8'h00);
    send_request(rfws_pkg::OP_FIND, 32'h0, 8'h00);
    send_request(rfws_pkg::OP_REVERSE, 32'h0, 8'h00);
    for (int c = OP_UNUSED_FIRST; c <= OP_UNUSED_LAST; c++) begin
      send_request(3'(c), 32'hFFFF_FFFF, 8'hFF);
    end
    send_request(rfws_pkg::OP_ENQUEUE, 32'h0000_0000, 8'h00);
    send_request(rfws_pkg::OP_REVERSE, 32'h0, 8'h00);
    send_request(rfws_pkg::OP_ENQUEUE, 32'hFFFF_FFFF, 8'hFF);
    send_request(rfws_pkg::OP_ENQUEUE, 32'h1234_5678, 8'h00);
    for (int n = 0; n < 3; n++) begin
      send_request(rfws_pkg::OP_READ_NTH, 32'h0, 8'(n));
    end
    send_request(rfws_pkg::OP_READ_NTH, 32'h0, 8'hFF);
    send_request(rfws_pkg::OP_REVERSE, 32'h0, 8'h00);
    send_request(rfws_pkg::OP_READ_NTH, 32'h0, 8'h00);
    send_request(rfws_pkg::OP_FIND, 32'hFFFF_FFFF, 8'h00);
    send_request(rfws_pkg::OP_FIND, 32'h0000_0000, 8'h00);
    send_request(rfws_pkg::OP_FIND, 32'h8000_0001, 8'h00);
    send_request(OP_UNUSED_LAST, 32'h0, 8'h00);
    repeat (4) send_request(rfws_pkg::OP_DEQUEUE, 32'h0, 8'h00);
  endtask

  task automatic test_full_queue();
    while (mirror_count < rfws_pkg::CNT_W'(rfws_pkg::QUEUE_DEPTH)) begin
      send_request(rfws_pkg::OP_ENQUEUE, $urandom, 8'h00);
    end
    repeat (2) send_request(rfws_pkg::OP_ENQUEUE, $urandom, 8'h00);
    send_request(rfws_pkg::OP_READ_NTH, 32'h0, 8'hFF);
    send_request(rfws_pkg::OP_FIND, mirror_value(rfws_pkg::QUEUE_DEPTH - 1), 8'h00);
    send_request(rfws_pkg::OP_FIND, $urandom, 8'h00);
    send_request(rfws_pkg::OP_REVERSE, 32'h0, 8'h00);
    send_request(rfws_pkg::OP_ENQUEUE, $urandom, 8'h00);
    send_request(rfws_pkg::OP_DEQUEUE, 32'h0, 8'h00);
    send_request(rfws_pkg::OP_ENQUEUE, 32'hA5A5_5A5A, 8'h00);
    send_request(rfws_pkg::OP_READ_NTH, 32'h0, 8'hFF);
    send_request(rfws_pkg::OP_READ_NTH, 32'h0, 8'h00);
    send_request(rfws_pkg::OP_REVERSE, 32'h0, 8'h00);
    while (mirror_count > 16) begin
      send_request(rfws_pkg::OP_DEQUEUE, $urandom, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_random_traffic(input int unsigned n_items, input logic allow_idle);
    logic [2:0]                      op;
    logic [rfws_pkg::DATA_WIDTH-1:0] val;
    logic [7:0]                      idx;
    int unsigned                     pick;
    int unsigned                     enq_weight;
    for (int unsigned k = 0; k < n_items; k++) begin
      if (k % 64 == 0) idle_on = allow_idle && ($urandom_range(0, 3) != 0);
      enq_weight = (mirror_count < 8) ? 45 : (mirror_count > 48) ? 12 : 30;
      pick = $urandom_range(0, 99);
      if (pick < enq_weight) op = rfws_pkg::OP_ENQUEUE;
      else if (pick < enq_weight + 20) op = rfws_pkg::OP_DEQUEUE;
      else if (pick < enq_weight + 30) op = rfws_pkg::OP_REVERSE;
      else if (pick < enq_weight + 48) op = rfws_pkg::OP_READ_NTH;
      else if (pick < 96) op = rfws_pkg::OP_FIND;
      else op = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
      val = ($urandom_range(0, 1) == 0) ?
            rfws_pkg::DATA_WIDTH'($urandom_range(0, 15)) : $urandom;
      if (op == rfws_pkg::OP_FIND && mirror_count != 0 && $urandom_range(0, 9) < 6) begin
        val = mirror_value($urandom_range(0, int'(mirror_count) - 1));
      end
      if (mirror_count != 0 && $urandom_range(0, 9) < 8) begin
        idx = 8'($urandom_range(0, int'(mirror_count) - 1));
      end else begin
        idx = 8'($urandom_range(0, 255));
      end
      send_request(op, val, idx);
    end
  endtask

  task automatic test_drain_pause();
    request_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst     <= 1'b0;
    idle_on = 1'b1;
    test_directed_edges();
    test_full_queue();
    test_random_traffic(250, 1'b1);
    test_drain_pause();
    test_random_traffic(200, 1'b1);
    test_random_traffic(120, 1'b0);
    request_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
